/* design/assert_macros.svh */
// assertion macros for the rule table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

/* design/pst_pkg.sv */
// package for the rule table: types, codes and sizes
package pst_pkg;
   localparam int CAPACITY_DEF = 256;
   localparam int DIMENSIONS_DEF = 5;
   localparam int RANGE_WIDTH_DEF = 32;
   localparam int MAX_DIMS = 5;
   localparam logic [31:0] WILDCARD_PRI = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0, CMD_FIND = 2'd1, CMD_DELETE = 2'd2, CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_EXISTS = 2'd1, ST_NOT_FOUND = 2'd2, ST_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_WALK, S_SHIFT_UP, S_SHIFT_DN, S_WRITE, S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] priority_req;
      logic [31:0] low_dim0;
      logic [31:0] high_dim0;
      logic [31:0] low_dim1;
      logic [31:0] high_dim1;
      logic [31:0] low_dim2;
      logic [31:0] high_dim2;
      logic [31:0] low_dim3;
      logic [31:0] high_dim3;
      logic [31:0] low_dim4;
      logic [31:0] high_dim4;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] position;
      logic [8:0] entries_held;
   } rsp_type;
endpackage

/* design/pst_if.sv */
// valid/ready channel interfaces
interface pst_req_if;
   import pst_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pst_rsp_if;
   import pst_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/priority_sorted_rule_table.sv */
// top level of the priority sorted rule table
//
// req channel carries add, find and delete commands; rsp channel returns one
// status, position and entry count per command. a command is taken only when
// the block is idle and its response register is free.
// a command scans the table once (one entry per cycle); all but a wildcard find
// or delete then walk back over equal priorities (one entry per cycle); then add
// shifts the tail up and delete shifts it down, reading each entry and then
// writing it back. the entry memory takes one registered read and one write
// each cycle.
// each entry is one memory word holding its priority and all ranges.
// reset clears the entry count and the state machine; memory contents are
// left alone, as no entry at or above the count is ever used.
// while the receiver stalls, the response stays in its register and no new
// command is taken.
`include "assert_macros.svh"
module priority_sorted_rule_table #(
   parameter int CAPACITY = pst_pkg::CAPACITY_DEF,
   parameter int DIMENSIONS = pst_pkg::DIMENSIONS_DEF,
   parameter int RANGE_WIDTH = pst_pkg::RANGE_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   pst_req_if.sink req,
   pst_rsp_if.source rsp
);
   import pst_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = 2 * RANGE_WIDTH * DIMENSIONS;
   localparam int WW = 32 + RW;

   logic [WW-1:0] mem [CAPACITY];
   logic [WW-1:0] rd_ff;
   logic [AW-1:0] raddr;
   logic          we;
   logic [AW-1:0] waddr;
   logic [WW-1:0] wdata;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          rdv_ff, rdv_in;
   cmd_type       cmd_ff, cmd_in;
   logic [31:0]   pri_ff, pri_in;
   logic [RW-1:0] rng_ff, rng_in;
   logic          rv_ff, rv_in;
   rsp_type       rsp_ff, rsp_in;
   logic [RW-1:0] req_rng;
   logic [31:0]   rd_pri;
   logic          rd_eq;

   always_comb begin
      logic [MAX_DIMS*64-1:0] all;
      all = {req.payload.high_dim4, req.payload.low_dim4,
             req.payload.high_dim3, req.payload.low_dim3,
             req.payload.high_dim2, req.payload.low_dim2,
             req.payload.high_dim1, req.payload.low_dim1,
             req.payload.high_dim0, req.payload.low_dim0};
      req_rng = '0;
      for (int d = 0; d < DIMENSIONS; d++) begin
         req_rng[2*RANGE_WIDTH*d +: RANGE_WIDTH] = all[64*d +: RANGE_WIDTH];
         req_rng[2*RANGE_WIDTH*d + RANGE_WIDTH +: RANGE_WIDTH] =
            all[64*d + 32 +: RANGE_WIDTH];
      end
   end

   assign rd_pri = rd_ff[WW-1 -: 32];
   assign rd_eq = (rd_ff[RW-1:0] == rng_ff);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff <= 1'b0;
         rdv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff <= rv_in;
         rdv_ff <= rdv_in;
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      cmd_ff <= cmd_in;
      pri_ff <= pri_in;
      rng_ff <= rng_in;
      rsp_ff <= rsp_in;
   end

   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      cmd_in = cmd_ff;
      pri_in = pri_ff;
      rng_in = rng_ff;
      rv_in = rv_ff && !rsp.ready;
      rsp_in = rsp_ff;
      rdv_in = 1'b0;
      raddr = idx_ff[AW-1:0];
      we = 1'b0;
      waddr = idx_ff[AW-1:0];
      wdata = rd_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = cmd_type'(req.payload.command);
               pri_in = req.payload.priority_req;
               rng_in = req_rng;
               idx_in = '0;
               pos_in = '0;
               raddr = '0;
               rdv_in = (count_ff != '0);
               case (cmd_type'(req.payload.command))
                  CMD_ADD: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        rsp_in = '{ST_FULL, 8'd0, 9'(count_ff)};
                        state_in = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_FIND, CMD_DELETE: state_in = S_SCAN;
                  default: begin
                     rsp_in = '{ST_OK, 8'd0, 9'(count_ff)};
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // forward scan: wildcard find or delete looks for match, others for first above
            if (!rdv_ff) begin
               if (idx_ff == count_ff) begin
                  if (cmd_ff != CMD_ADD && pri_ff == WILDCARD_PRI) begin
                     rsp_in = '{ST_NOT_FOUND, 8'd0, 9'(count_ff)};
                     state_in = S_RESP;
                  end else begin
                     pos_in = idx_ff;
                     state_in = S_WALK;
                     rdv_in = (idx_ff != '0);
                     raddr = AW'(idx_ff - 1'b1);
                     idx_in = idx_ff;
                  end
               end else begin
                  rdv_in = 1'b1;
               end
            end else if (cmd_ff != CMD_ADD && pri_ff == WILDCARD_PRI) begin
               if (rd_eq) begin
                  pos_in = idx_ff;
                  state_in = S_WRITE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  raddr = AW'(idx_ff + 1'b1);
                  rdv_in = (idx_ff + 1'b1 != count_ff);
               end
            end else if (rd_pri > pri_ff) begin
               pos_in = idx_ff;
               state_in = S_WALK;
               rdv_in = (idx_ff != '0);
               raddr = AW'(idx_ff - 1'b1);
            end else begin
               idx_in = idx_ff + 1'b1;
               raddr = AW'(idx_ff + 1'b1);
               rdv_in = (idx_ff + 1'b1 != count_ff);
            end
         end
         S_WALK: begin
            // idx_ff is one above the entry in rd_ff
            if (rdv_ff && rd_pri == pri_ff && rd_eq) begin
               if (cmd_ff == CMD_ADD) begin
                  rsp_in = '{ST_EXISTS, 8'(idx_ff - 1'b1), 9'(count_ff)};
                  state_in = S_RESP;
               end else begin
                  pos_in = idx_ff - 1'b1;
                  idx_in = idx_ff - 1'b1;
                  state_in = S_WRITE;
               end
            end else if (rdv_ff && rd_pri == pri_ff) begin
               idx_in = idx_ff - 1'b1;
               raddr = AW'(idx_ff - 2'd2);
               rdv_in = (idx_ff != CW'(1));
            end else if (cmd_ff == CMD_ADD) begin
               idx_in = count_ff;
               raddr = AW'(count_ff - 1'b1);
               rdv_in = 1'b0;
               state_in = S_SHIFT_UP;
            end else begin
               rsp_in = '{ST_NOT_FOUND, 8'd0, 9'(count_ff)};
               state_in = S_RESP;
            end
         end
         S_WRITE: begin
            if (cmd_ff == CMD_DELETE) begin
               idx_in = pos_ff;
               raddr = AW'(pos_ff + 1'b1);
               rdv_in = 1'b0;
               state_in = S_SHIFT_DN;
            end else begin
               rsp_in = '{ST_OK, 8'(pos_ff), 9'(count_ff)};
               state_in = S_RESP;
            end
         end
         S_SHIFT_UP: begin
            // idx_ff: slot to fill; rd_ff holds entry idx_ff-1 once read
            if (idx_ff == pos_ff) begin
               we = 1'b1;
               wdata = {pri_ff, rng_ff};
               count_in = count_ff + 1'b1;
               rsp_in = '{ST_OK, 8'(pos_ff), 9'(count_ff + 1'b1)};
               state_in = S_RESP;
            end else if (!rdv_ff) begin
               raddr = AW'(idx_ff - 1'b1);
               rdv_in = 1'b1;
            end else begin
               we = 1'b1;
               idx_in = idx_ff - 1'b1;
               raddr = AW'(idx_ff - 2'd2);
               rdv_in = 1'b0;
            end
         end
         S_SHIFT_DN: begin
            if (idx_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               rsp_in = '{ST_OK, 8'(pos_ff), 9'(count_ff - 1'b1)};
               state_in = S_RESP;
            end else if (!rdv_ff) begin
               raddr = AW'(idx_ff + 1'b1);
               rdv_in = 1'b1;
            end else begin
               we = 1'b1;
               idx_in = idx_ff + 1'b1;
               raddr = AW'(idx_ff + 2'd2);
               rdv_in = 1'b0;
            end
         end
         S_RESP: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   `ASSERT_IMPLIES(a_count_max, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `ASSERT_IMPLIES(a_no_take_busy, clock, reset, rv_ff, !req.ready)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && !rsp.ready, rv_ff && $stable(rsp_ff))
   `ASSERT_IMPLIES(a_write_bound, clock, reset, we, idx_ff <= count_ff)
endmodule
